// File: hdl/alist_pkg.sv
// Shared constants and sizes for the array list block.
package alist_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > 4) ? CNT_W : 4;
    localparam int DATA_W   = 32;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_INSERT = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_SEARCH = 3'd4;
    localparam logic [2:0] CMD_READ   = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

// File: hdl/alist_if.sv
// Command and response channel interfaces for the array list block.
interface alist_in_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  command;
    logic        [3:0]  position;
    logic signed [31:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface alist_out_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic        [3:0]  found_index;
    logic signed [31:0] read_value;
    logic        [4:0]  length;

    modport source (output valid, status, found_index, read_value, length, input ready);
    modport sink   (input valid, status, found_index, read_value, length, output ready);
endinterface

// File: hdl/alist_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module alist_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int AW     = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/array_list_insert_delete_search_top.sv
// Array list sequencer: clear, append, insert, delete, search and read on a RAM.
// Insert and delete move the tail elements one slot at a time through the RAM, and a search
// scans the elements in order through the shared compare until the first match.
// Not ready while a command runs; a new command is taken only once the last response is loaded.
// Synchronous active-low reset empties the list; element storage is not cleared.
module array_list_insert_delete_search_top
    import alist_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    alist_in_if.sink    i_cmd,
    alist_out_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_INS, S_DEL, S_SRCH, S_RD, S_RESP
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_cmd;
    logic [3:0]         r_pos;
    logic [DATA_W-1:0]  r_val;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_k, n_k;
    logic               r_pend, n_pend;
    logic [ADDR_W-1:0]  r_pend_addr, n_pend_addr;
    logic [1:0]         r_res_status, n_res_status;
    logic [ADDR_W-1:0]  r_res_found, n_res_found;
    logic [DATA_W-1:0]  r_res_read, n_res_read;

    logic               r_ov;
    logic [1:0]         r_o_status;
    logic [3:0]         r_o_found;
    logic [DATA_W-1:0]  r_o_read;
    logic [4:0]         r_o_length;
    logic               load_out;

    logic               we;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [DATA_W-1:0]  wdata, rdata;

    logic [CMP_W-1:0]   pos_ext, cnt_ext, k_ext;
    logic [CNT_W-1:0]   k_m1, k_p1, pos_p1;
    logic               hit;

    alist_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W),
        .AW    (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign pos_ext = CMP_W'(r_pos);
    assign cnt_ext = CMP_W'(r_count);
    assign k_ext   = CMP_W'(r_k);
    assign k_m1    = r_k - CNT_W'(1);
    assign k_p1    = r_k + CNT_W'(1);
    assign pos_p1  = CNT_W'(pos_ext) + CNT_W'(1);
    // The single comparator shared by every scan step.
    assign hit     = (rdata == r_val);

    assign i_cmd.ready = (r_state == S_IDLE);
    assign load_out    = (r_state == S_RESP) && (!r_ov || o_rsp.ready);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_k          = r_k;
        n_pend       = r_pend;
        n_pend_addr  = r_pend_addr;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_read   = r_res_read;
        we           = 1'b0;
        waddr        = r_pend_addr;
        wdata        = rdata;
        raddr        = k_m1[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status = ST_OK;
                n_res_found  = '0;
                n_res_read   = '0;
                n_pend       = 1'b0;
                n_state      = S_RESP;
                priority case (r_cmd)
                    CMD_CLEAR: begin
                        n_count = '0;
                    end
                    CMD_APPEND: begin
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            we      = 1'b1;
                            waddr   = r_count[ADDR_W-1:0];
                            wdata   = r_val;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    CMD_INSERT: begin
                        if (pos_ext > cnt_ext) begin
                            n_res_status = ST_BADPOS;
                        end else if (r_count >= CNT_W'(CAPACITY)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            n_k     = r_count;
                            n_state = S_INS;
                        end
                    end
                    CMD_DELETE: begin
                        if (pos_ext >= cnt_ext) begin
                            n_res_status = ST_BADPOS;
                        end else begin
                            n_k     = pos_p1;
                            n_state = S_DEL;
                        end
                    end
                    CMD_SEARCH: begin
                        n_k     = '0;
                        n_state = S_SRCH;
                    end
                    CMD_READ: begin
                        if (pos_ext >= cnt_ext) begin
                            n_res_status = ST_BADPOS;
                        end else begin
                            raddr   = pos_ext[ADDR_W-1:0];
                            n_state = S_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_INS: begin
                // Move the tail up one slot: read k-1 now, write it to k next cycle.
                if (r_pend) begin
                    we = 1'b1;
                end
                if (k_ext != pos_ext) begin
                    raddr       = k_m1[ADDR_W-1:0];
                    n_pend      = 1'b1;
                    n_pend_addr = r_k[ADDR_W-1:0];
                    n_k         = k_m1;
                end else if (!r_pend) begin
                    we      = 1'b1;
                    waddr   = pos_ext[ADDR_W-1:0];
                    wdata   = r_val;
                    n_count = r_count + CNT_W'(1);
                    n_state = S_RESP;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_DEL: begin
                if (r_pend) begin
                    we = 1'b1;
                end
                if (r_k < r_count) begin
                    raddr       = r_k[ADDR_W-1:0];
                    n_pend      = 1'b1;
                    n_pend_addr = k_m1[ADDR_W-1:0];
                    n_k         = k_p1;
                end else if (!r_pend) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_RESP;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_SRCH: begin
                if (r_pend && hit) begin
                    n_res_found = r_pend_addr;
                    n_state     = S_RESP;
                end else if (r_k < r_count) begin
                    raddr       = r_k[ADDR_W-1:0];
                    n_pend      = 1'b1;
                    n_pend_addr = r_k[ADDR_W-1:0];
                    n_k         = k_p1;
                end else begin
                    n_res_status = ST_NOTFOUND;
                    n_state      = S_RESP;
                end
            end
            S_RD: begin
                n_res_read = rdata;
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd <= i_cmd.command;
            r_pos <= i_cmd.position;
            r_val <= i_cmd.value;
        end
        r_k          <= n_k;
        r_pend_addr  <= n_pend_addr;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_read   <= n_res_read;
        if (load_out) begin
            r_o_status <= r_res_status;
            r_o_found  <= 4'(r_res_found);
            r_o_read   <= r_res_read;
            r_o_length <= 5'(r_count);
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.found_index = r_o_found;
    assign o_rsp.read_value  = r_o_read;
    assign o_rsp.length      = r_o_length;

endmodule
